FILE: hdl/seven_segment_mux_controller_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the seven-segment display controller
// Clocked concurrent assertion wrappers, with and without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_MUX_CONTROLLER_ASSERT_SVH
`define SEVEN_SEGMENT_MUX_CONTROLLER_ASSERT_SVH

// check a property outside of reset
`define SSMC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ssmc assertion failed");

// check a property on every edge, reset included
`define SSMC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ssmc assertion failed");

`endif

FILE: hdl/ssmc_pkg.sv
// ---------------------------------------------------------------------------
// ssmc_pkg
// Types, constants and decimal helpers of the seven-segment display controller.
// ---------------------------------------------------------------------------
package ssmc_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int GLYPH_COUNT = 17;
   localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0]  DOT_BIT            = 8'h80;
   localparam logic [7:0]  BLANK_PATTERN      = 8'h00;
   localparam logic [7:0]  FULL_PATTERN       = 8'hFF;
   localparam logic [7:0]  GLYPH_C            = 8'd12;
   localparam logic [7:0]  GLYPH_H            = 8'd16;
   localparam logic [15:0] FLASH_PERIOD_RESET = 16'd500;

   localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
      8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h74
   };

   typedef enum logic [3:0] {
      ACT_SCAN  = 4'd0,
      ACT_TIME  = 4'd1,
      ACT_RAW   = 4'd2,
      ACT_GLYPH = 4'd3,
      ACT_COLON = 4'd4,
      ACT_DOT   = 4'd5,
      ACT_HHMM  = 4'd6,
      ACT_MMDD  = 4'd7,
      ACT_YEAR  = 4'd8,
      ACT_TEMP  = 4'd9,
      ACT_HUMID = 4'd10,
      ACT_CLEAR = 4'd11,
      ACT_SET   = 4'd12
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FLASH_COLON   = 3'd0,
      CSR_FLASH_MINUTES = 3'd1,
      CSR_FLASH_HOURS   = 3'd2,
      CSR_FLASH_EVERY   = 3'd3,
      CSR_FLASH_PERIOD  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic              flash_colon_on;
      logic              flash_minutes_on;
      logic              flash_hours_on;
      logic              flash_every_digit;
      logic [15:0]       flash_period_ms;
   } ssmc_cfg_type;

   typedef struct packed {
      logic [3:0]        action;
      logic [1:0]        digit_position;
      logic [7:0]        data_byte;
      logic signed [16:0] value_first;
      logic [7:0]        value_second;
      logic [31:0]       time_ms;
   } ssmc_item_type;

   typedef struct packed {
      logic                               scan;
      logic                               flash;
      logic                               clear;
      logic                               set;
      logic                               colon_wr;
      logic                               colon_value;
      logic [DIGIT_COUNT-1:0]             wr_mask;
      logic [DIGIT_COUNT-1:0][7:0]        wr_pattern;
      logic [DIGIT_COUNT-1:0]             dot_mask;
      logic [31:0]                        time_ms;
   } ssmc_cmd_type;

   typedef struct packed {
      logic [3:0] digit_select_n;
      logic [7:0] segments_n;
      logic       colon_drive;
   } ssmc_result_type;

   // blank for any index past the table
   function automatic logic [7:0] glyph_pattern(input logic [7:0] idx);
      logic [7:0] pat;
      pat = BLANK_PATTERN;
      if (idx < 8'(GLYPH_COUNT)) begin
         pat = GLYPH_ROM[idx[GLYPH_IDX_W-1:0]];
      end
      return pat;
   endfunction

   function automatic logic signed [16:0] clamp_s17(input logic signed [16:0] v,
                                                    input logic signed [16:0] lo,
                                                    input logic signed [16:0] hi);
      logic signed [16:0] r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   // reciprocal multiplies, exact for inputs below 16384
   function automatic logic [13:0] div10(input logic [13:0] x);
      logic [29:0] p;
      p = 30'(x) * 30'd52429;
      return {3'b000, p[29:19]};
   endfunction

   function automatic logic [13:0] div100(input logic [13:0] x);
      logic [26:0] p;
      p = 27'(x) * 27'd5243;
      return {6'b000000, p[26:19]};
   endfunction

   function automatic logic [13:0] div1000(input logic [13:0] x);
      logic [27:0] p;
      p = 28'(x) * 28'd8389;
      return {9'b000000000, p[27:23]};
   endfunction

   function automatic logic [13:0] times10(input logic [13:0] x);
      return 14'({x, 3'b000} + {x, 1'b0});
   endfunction

endpackage

FILE: hdl/ssmc_channels.sv
// ---------------------------------------------------------------------------
// ssmc channel interfaces
// Valid/ready request and response channels of the display controller.
// ---------------------------------------------------------------------------
interface ssmc_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         action;
   logic [1:0]         digit_position;
   logic [7:0]         data_byte;
   logic signed [16:0] value_first;
   logic [7:0]         value_second;
   logic [31:0]        time_ms;

   modport source (output valid, action, digit_position, data_byte, value_first,
                   value_second, time_ms, input ready);
   modport sink   (input valid, action, digit_position, data_byte, value_first,
                   value_second, time_ms, output ready);
endinterface

interface ssmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] digit_select_n;
   logic [7:0] segments_n;
   logic       colon_drive;

   modport source (output valid, digit_select_n, segments_n, colon_drive, input ready);
   modport sink   (input valid, digit_select_n, segments_n, colon_drive, output ready);
endinterface

FILE: hdl/seven_segment_mux_controller.sv
// ---------------------------------------------------------------------------
// seven_segment_mux_controller
// Four-digit multiplexed seven-segment display driver with colon.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one command: a scan tick, a flash time event, clear, set,
//   or a write of raw bytes, glyphs, colon, decimal points or formatted values.
//   Only a scan tick produces a transaction on rsp_ch: the active-low digit
//   strobe, the inverted segments of that digit and the colon level.
//   csr_* writes the flash flags and flash period; write them while idle.
// Timing:
//   A request is captured in an input register, applied to the display state
//   as it leaves that register, and its scan result lands in the output
//   register at the same edge. One transaction per cycle is sustained unless
//   a scan tick waits on a stalled rsp_ch; the path from the input register
//   through the decimal formatting (reciprocal multiplies and glyph lookup)
//   into the state registers is the critical stage.
// Reset and stall:
//   Reset clears the display, enables, colon, scan index and flash timer,
//   sets the held segments to all ones and the flash period to 500 ms.
//   While rsp_ch is stalled with a result pending, non-scan commands still
//   go through; a scan tick waits in the input register and holds req_ch.
// ---------------------------------------------------------------------------
module seven_segment_mux_controller import ssmc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   ssmc_req_if.sink               req_ch,
   ssmc_rsp_if.source             rsp_ch,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ssmc_cfg_type    cfg_ff, cfg_in;
   ssmc_item_type   item_ff, item_in;
   logic            in_valid_ff, in_valid_in;
   ssmc_result_type out_ff, out_in;
   logic            out_valid_ff, out_valid_in;
   ssmc_cmd_type    cmd;
   ssmc_result_type result;
   logic            req_accept;
   logic            advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_FLASH_COLON:   cfg_in.flash_colon_on    = csr_wdata[0];
            CSR_FLASH_MINUTES: cfg_in.flash_minutes_on  = csr_wdata[0];
            CSR_FLASH_HOURS:   cfg_in.flash_hours_on    = csr_wdata[0];
            CSR_FLASH_EVERY:   cfg_in.flash_every_digit = csr_wdata[0];
            CSR_FLASH_PERIOD:  cfg_in.flash_period_ms   = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   ssmc_format u_format (
      .item (item_ff),
      .cmd  (cmd)
   );

   ssmc_display_state u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cmd     (cmd),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // a scan may only move on when the output register has room
   assign advance      = in_valid_ff && (!cmd.scan || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !reset && (!in_valid_ff || advance);
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      item_in.action         = req_ch.action;
      item_in.digit_position = req_ch.digit_position;
      item_in.data_byte      = req_ch.data_byte;
      item_in.value_first    = req_ch.value_first;
      item_in.value_second   = req_ch.value_second;
      item_in.time_ms        = req_ch.time_ms;

      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (advance && cmd.scan) begin
         out_in       = result;
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{flash_colon_on:    1'b0,
                           flash_minutes_on:  1'b0,
                           flash_hours_on:    1'b0,
                           flash_every_digit: 1'b0,
                           flash_period_ms:   FLASH_PERIOD_RESET};
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
      out_ff <= out_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.digit_select_n = out_ff.digit_select_n;
   assign rsp_ch.segments_n     = out_ff.segments_n;
   assign rsp_ch.colon_drive    = out_ff.colon_drive;

endmodule

FILE: hdl/ssmc_format.sv
// ---------------------------------------------------------------------------
// ssmc_format
// Decodes one registered transaction into digit writes and state commands.
// ---------------------------------------------------------------------------
module ssmc_format import ssmc_pkg::*; (
   input  ssmc_item_type item,
   output ssmc_cmd_type  cmd
);

   logic signed [16:0] hour_s, month_s, year_s, temp_s, humid_s, temp_abs;
   logic [5:0]         minute, day, pair_a, pair_b;
   logic [13:0]        a_q, b_q, a_r, b_r;
   logic               temp_neg;
   logic [13:0]        num, q10, q100, q1000, r0, r1, r2;
   logic [7:0]         d0, d1, d2, d3, hundreds;
   logic [3:0]         pos_mask;
   logic [7:0]         tenths_p0, tenths_p1, tenths_p2;

   always_comb begin
      hour_s   = clamp_s17(item.value_first, 17'sd0, 17'sd23);
      month_s  = clamp_s17(item.value_first, 17'sd1, 17'sd12);
      year_s   = clamp_s17(item.value_first, 17'sd0, 17'sd9999);
      temp_s   = clamp_s17(item.value_first, -17'sd400, 17'sd1250);
      humid_s  = clamp_s17(item.value_first, 17'sd0, 17'sd1000);
      temp_neg = temp_s[16];
      temp_abs = temp_neg ? 17'(-temp_s) : temp_s;

      minute = (item.value_second > 8'd59) ? 6'd59 : item.value_second[5:0];
      if (item.value_second == 8'd0) begin
         day = 6'd1;
      end else if (item.value_second > 8'd31) begin
         day = 6'd31;
      end else begin
         day = item.value_second[5:0];
      end
   end

   // two-digit pairs
   always_comb begin
      pair_a = (action_type'(item.action) == ACT_MMDD) ? month_s[5:0] : hour_s[5:0];
      pair_b = (action_type'(item.action) == ACT_MMDD) ? day : minute;
      a_q    = div10({8'b0, pair_a});
      b_q    = div10({8'b0, pair_b});
      a_r    = 14'({8'b0, pair_a} - times10(a_q));
      b_r    = 14'({8'b0, pair_b} - times10(b_q));
   end

   // shared decimal split for year, temperature and humidity
   always_comb begin
      case (action_type'(item.action))
         ACT_YEAR: num = year_s[13:0];
         ACT_TEMP: num = temp_abs[13:0];
         default:  num = humid_s[13:0];
      endcase
      q10      = div10(num);
      q100     = div100(num);
      q1000    = div1000(num);
      r0       = 14'(num - times10(q10));
      r1       = 14'(q10 - times10(q100));
      r2       = 14'(q100 - times10(q1000));
      d0       = {4'b0, r0[3:0]};
      d1       = {4'b0, r1[3:0]};
      d2       = {4'b0, r2[3:0]};
      d3       = {4'b0, q1000[3:0]};
      hundreds = q100[7:0];

      tenths_p0 = glyph_pattern(hundreds);
      tenths_p1 = glyph_pattern(d1) | DOT_BIT;
      tenths_p2 = glyph_pattern(d0);
   end

   always_comb begin
      pos_mask = 4'b0001 << item.digit_position;

      cmd             = '0;
      cmd.time_ms     = item.time_ms;
      cmd.colon_value = item.data_byte[0];

      case (action_type'(item.action))
         ACT_SCAN:  cmd.scan = 1'b1;
         ACT_TIME:  cmd.flash = 1'b1;
         ACT_RAW: begin
            cmd.wr_mask = pos_mask;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               cmd.wr_pattern[i] = item.data_byte;
            end
         end
         ACT_GLYPH: begin
            cmd.wr_mask = pos_mask;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               cmd.wr_pattern[i] = glyph_pattern(item.data_byte);
            end
         end
         ACT_COLON: cmd.colon_wr = 1'b1;
         ACT_DOT:   cmd.dot_mask = pos_mask;
         ACT_HHMM, ACT_MMDD: begin
            cmd.wr_mask       = 4'hF;
            cmd.wr_pattern[0] = glyph_pattern(a_q[7:0]);
            cmd.wr_pattern[1] = glyph_pattern(a_r[7:0]);
            cmd.wr_pattern[2] = glyph_pattern(b_q[7:0]);
            cmd.wr_pattern[3] = glyph_pattern(b_r[7:0]);
         end
         ACT_YEAR: begin
            cmd.wr_mask       = 4'hF;
            cmd.wr_pattern[0] = glyph_pattern(d3);
            cmd.wr_pattern[1] = glyph_pattern(d2);
            cmd.wr_pattern[2] = glyph_pattern(d1);
            cmd.wr_pattern[3] = glyph_pattern(d0);
         end
         ACT_TEMP: begin
            cmd.wr_mask       = 4'hF;
            cmd.wr_pattern[0] = temp_neg ? (tenths_p0 | DOT_BIT) : tenths_p0;
            cmd.wr_pattern[1] = tenths_p1;
            cmd.wr_pattern[2] = tenths_p2;
            cmd.wr_pattern[3] = glyph_pattern(GLYPH_C);
         end
         ACT_HUMID: begin
            cmd.wr_mask       = 4'hF;
            cmd.wr_pattern[0] = tenths_p0;
            cmd.wr_pattern[1] = tenths_p1;
            cmd.wr_pattern[2] = tenths_p2;
            cmd.wr_pattern[3] = glyph_pattern(GLYPH_H);
         end
         ACT_CLEAR: cmd.clear = 1'b1;
         ACT_SET:   cmd.set = 1'b1;
         default:   cmd.scan = 1'b0;
      endcase
   end

endmodule

FILE: hdl/ssmc_display_state.sv
// ---------------------------------------------------------------------------
// ssmc_display_state
// Digit patterns, enables, colon, scan index and flash timer, plus scan result.
// ---------------------------------------------------------------------------
module ssmc_display_state import ssmc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  ssmc_cmd_type    cmd,
   input  ssmc_cfg_type    cfg,
   output ssmc_result_type result
);

   logic [DIGIT_COUNT-1:0][7:0] pattern_ff, pattern_in;
   logic [DIGIT_COUNT-1:0]      enable_ff, enable_in;
   logic                        colon_ff, colon_in;
   logic [1:0]                  index_ff, index_in;
   logic [31:0]                 last_flash_ff, last_flash_in;
   logic [7:0]                  hold_ff, hold_in;
   logic [31:0]                 elapsed;
   logic                        flip;
   logic                        busy;

   always_comb begin
      result.digit_select_n = 4'hF;
      result.segments_n     = hold_ff;
      result.colon_drive    = colon_ff;
      if (enable_ff[index_ff]) begin
         result.digit_select_n = ~(4'b1000 >> index_ff);
         result.segments_n     = ~pattern_ff[index_ff];
      end
   end

   always_comb begin
      pattern_in    = pattern_ff;
      enable_in     = enable_ff;
      colon_in      = colon_ff;
      index_in      = index_ff;
      last_flash_in = last_flash_ff;
      hold_in       = hold_ff;
      elapsed       = cmd.time_ms - last_flash_ff;
      flip          = 1'b0;
      busy          = 1'b0;

      if (advance) begin
         if (cmd.scan) begin
            hold_in  = result.segments_n;
            index_in = index_ff + 2'd1;
         end

         // toggles apply in order: colon, minutes, hours, every digit
         if (cmd.flash && (elapsed > {16'b0, cfg.flash_period_ms})) begin
            last_flash_in = cmd.time_ms;
            if (cfg.flash_colon_on) begin
               colon_in = ~colon_ff;
            end
            if (cfg.flash_minutes_on) begin
               flip         = ~enable_in[3];
               enable_in[3] = flip;
               enable_in[2] = flip;
            end
            if (cfg.flash_hours_on) begin
               flip         = ~enable_in[1];
               enable_in[1] = flip;
               enable_in[0] = flip;
            end
            if (cfg.flash_every_digit) begin
               flip      = ~enable_in[1];
               enable_in = {DIGIT_COUNT{flip}};
            end
         end

         if (cmd.clear) begin
            pattern_in = '0;
            enable_in  = '0;
            colon_in   = 1'b0;
         end
         if (cmd.set) begin
            pattern_in = {DIGIT_COUNT{FULL_PATTERN}};
            enable_in  = '1;
            colon_in   = 1'b1;
         end
         if (cmd.colon_wr) begin
            colon_in = cmd.colon_value;
         end

         // a write enables its digit unless that digit's group is flashing
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            busy = (i >= 2) ? (cfg.flash_every_digit | cfg.flash_minutes_on)
                            : (cfg.flash_every_digit | cfg.flash_hours_on);
            if (cmd.wr_mask[i]) begin
               pattern_in[i] = cmd.wr_pattern[i];
               if (!busy) begin
                  enable_in[i] = 1'b1;
               end
            end
            if (cmd.dot_mask[i]) begin
               pattern_in[i] = pattern_in[i] | DOT_BIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff    <= '0;
         enable_ff     <= '0;
         colon_ff      <= 1'b0;
         index_ff      <= 2'd0;
         last_flash_ff <= 32'd0;
         hold_ff       <= FULL_PATTERN;
      end else begin
         pattern_ff    <= pattern_in;
         enable_ff     <= enable_in;
         colon_ff      <= colon_in;
         index_ff      <= index_in;
         last_flash_ff <= last_flash_in;
         hold_ff       <= hold_in;
      end
   end

endmodule

FILE: hdl/ssmc_checker.sv
// ---------------------------------------------------------------------------
// ssmc_checker
// Port-level checks of the display controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "seven_segment_mux_controller_assert.svh"

module ssmc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_digit_select_n,
   input logic [7:0] rsp_segments_n,
   input logic       rsp_colon_drive
);

   // hold a stalled result
   `SSMC_ASSERT(a_rsp_stall_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segments_n) && $stable(rsp_digit_select_n) && $stable(rsp_colon_drive))

   // at most one digit strobed per scan
   `SSMC_ASSERT(a_single_digit, clock, reset, rsp_valid |-> $countones(~rsp_digit_select_n) <= 1)

   // reset empties both registers; the input opens once reset drops
   `SSMC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && (reset || req_ready))

   // a newly valid result needs an earlier accepted transaction
   `SSMC_ASSERT(a_rsp_from_req, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))

endmodule

bind seven_segment_mux_controller ssmc_checker u_ssmc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_digit_select_n (rsp_ch.digit_select_n),
   .rsp_segments_n     (rsp_ch.segments_n),
   .rsp_colon_drive    (rsp_ch.colon_drive)
);
